@@ rtl/core/ifd_pkg.sv @@
// Shared types and constants for the interleaved frame deframer.
package ifd_pkg;

   // Byte that opens every interleaved frame
   localparam logic [7:0] MARKER_BYTE = 8'h24;

   // Width of the packed result data and flag groups
   localparam int unsigned RSP_DATA_WIDTH = 32;
   localparam int unsigned RSP_USER_WIDTH = 2;

   // Parser phase codes
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CHANNEL = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // One tagged payload byte
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  channel_id;
      logic        is_control;
      logic [15:0] frame_length;
      logic        first_of_frame;
      logic        last_of_frame;
   } result_type;

endpackage

@@ rtl/core/ifd_parser.sv @@
// Frame header parser: phase machine, held header fields and payload counter.
module ifd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,        // consume stream_byte this cycle
   input  logic [7:0]         stream_byte,
   output logic               emit,        // stream_byte is payload
   output ifd_pkg::result_type result
);

   ifd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_channel_ff, held_channel_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] new_length;
   logic        is_first;
   logic        is_last;

   // Hold phase and header fields; advance only on a consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ifd_pkg::PH_HUNT;
         held_channel_ff <= 8'd0;
         length_high_ff  <= 8'd0;
         held_length_ff  <= 16'd0;
         bytes_left_ff   <= 16'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         held_channel_ff <= held_channel_in;
         length_high_ff  <= length_high_in;
         held_length_ff  <= held_length_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   assign new_length = {length_high_ff, stream_byte};
   assign is_first   = (bytes_left_ff == held_length_ff);
   assign is_last    = (bytes_left_ff <= 16'd1);

   // Tag the current byte with the held header
   always_comb begin
      result.payload_byte   = stream_byte;
      result.channel_id     = held_channel_ff;
      result.is_control     = (held_channel_ff != 8'd0);
      result.frame_length   = held_length_ff;
      result.first_of_frame = is_first;
      result.last_of_frame  = is_last;
   end

   // Next phase and header capture
   always_comb begin
      phase_in        = phase_ff;
      held_channel_in = held_channel_ff;
      length_high_in  = length_high_ff;
      held_length_in  = held_length_ff;
      bytes_left_in   = bytes_left_ff;
      emit            = 1'b0;
      case (phase_ff)
         ifd_pkg::PH_CHANNEL: begin
            held_channel_in = stream_byte;
            phase_in        = ifd_pkg::PH_LEN_HI;
         end
         ifd_pkg::PH_LEN_HI: begin
            length_high_in = stream_byte;
            phase_in       = ifd_pkg::PH_LEN_LO;
         end
         ifd_pkg::PH_LEN_LO: begin
            held_length_in = new_length;
            bytes_left_in  = new_length;
            // Skip empty frames straight back to the hunt
            phase_in = (new_length == 16'd0) ? ifd_pkg::PH_HUNT : ifd_pkg::PH_PAYLOAD;
         end
         ifd_pkg::PH_PAYLOAD: begin
            emit = 1'b1;
            if (is_last) begin
               bytes_left_in = 16'd0;
               phase_in      = ifd_pkg::PH_HUNT;
            end else begin
               bytes_left_in = bytes_left_ff - 16'd1;
            end
         end
         default: begin
            // Hunt for the marker; unused codes hunt too
            phase_in = (stream_byte == ifd_pkg::MARKER_BYTE) ?
                       ifd_pkg::PH_CHANNEL : ifd_pkg::PH_HUNT;
         end
      endcase
   end

endmodule

@@ rtl/core/interleaved_frame_deframer.sv @@
// Top level of the interleaved frame deframer: input register, parser, result register.
//
//   Channel  Direction  Payload
//   req_     in         tdata[7:0] stream_byte
//   rsp_     out        tdata: payload_byte, channel_id, frame_length; tuser: flags;
//                       tlast: last_of_frame
//
// One byte per cycle sustained while rsp_tready keeps up. Each byte passes through
// the input register, then the phase update and counter decrement land it in the
// result register.
// Synchronous active-high reset returns the parser to the marker hunt.
// A stalled result blocks only bytes that would make a result; header and
// dropped bytes keep draining behind it.
module interleaved_frame_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] stream_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] payload_byte, [15:8] channel_id, [31:16] frame_length
   output logic [ifd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // [0] is_control, [1] first_of_frame
   output logic [ifd_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   output logic                                 rsp_tlast
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   ifd_pkg::result_type out_ff;
   ifd_pkg::result_type parse_result;
   logic                emit;
   logic                consume;
   logic                req_fire;

   ifd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (consume),
      .stream_byte (in_byte_ff),
      .emit        (emit),
      .result      (parse_result)
   );

   // Drain the input register unless its result would hit a full, stalled slot
   assign consume    = in_valid_ff && (!emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      if (consume && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (consume && emit) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.frame_length, out_ff.channel_id, out_ff.payload_byte};
   assign rsp_tuser  = {out_ff.first_of_frame, out_ff.is_control};
   assign rsp_tlast  = out_ff.last_of_frame;

endmodule

@@ test/tb_top.sv @@
// Testbench for the interleaved frame deframer: random stream with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_top;
   import ifd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned RANDOM_BYTES = 720;
   localparam int unsigned MAX_PRINTS = 50;

   // Track the parser state and hold the tagged bytes still owed by the block
   class deframe_scoreboard;
      phase_type phase;
      logic [7:0] chan;
      logic [7:0] len_hi;
      logic [15:0] length;
      logic [15:0] left;
      result_type owed[$];
      int errors;

      function new();
         phase = PH_HUNT;
         chan = '0;
         len_hi = '0;
         length = '0;
         left = '0;
         errors = 0;
      endfunction

      // Advance the parser by one accepted stream byte
      function void note_byte(logic [7:0] b);
         result_type r;
         case (phase)
            PH_CHANNEL: begin
               chan = b;
               phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_hi = b;
               phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length = {len_hi, b};
               left = length;
               phase = (length == 16'd0) ? PH_HUNT : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               r.payload_byte = b;
               r.channel_id = chan;
               r.is_control = (chan >= 8'd1);
               r.frame_length = length;
               r.first_of_frame = (left == length);
               r.last_of_frame = (left <= 16'd1);
               owed.push_back(r);
               if (r.last_of_frame) begin
                  left = '0;
                  phase = PH_HUNT;
               end else begin
                  left = left - 16'd1;
               end
            end
            // Unused codes behave as the marker hunt
            default: begin
               phase = (b == MARKER_BYTE) ? PH_CHANNEL : PH_HUNT;
            end
         endcase
      endfunction

      task report(string what, longint got, longint want);
         if (errors < MAX_PRINTS)
            $display("tb_top: mismatch in %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      // Compare one result transaction with the oldest owed byte
      task check_result(logic [RSP_DATA_WIDTH-1:0] data, logic [RSP_USER_WIDTH-1:0] user,
                        logic last);
         result_type want;
         if (owed.size() == 0) begin
            report("unexpected result", data, 0);
            return;
         end
         want = owed.pop_front();
         if (data[7:0] !== want.payload_byte)
            report("payload_byte", data[7:0], want.payload_byte);
         if (data[15:8] !== want.channel_id)
            report("channel_id", data[15:8], want.channel_id);
         if (data[31:16] !== want.frame_length)
            report("frame_length", data[31:16], want.frame_length);
         if (user[0] !== want.is_control)
            report("is_control", user[0], want.is_control);
         if (user[1] !== want.first_of_frame)
            report("first_of_frame", user[1], want.first_of_frame);
         if (last !== want.last_of_frame)
            report("last_of_frame", last, want.last_of_frame);
      endtask

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;
   logic rsp_tlast;

   deframe_scoreboard sb = new();

   bit send_quiet = 1'b0;
   bit drain_fast = 1'b0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int unsigned frame_bytes = 0;

   interleaved_frame_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one byte and wait for its transaction
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = send_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] chan, input logic [15:0] len);
      send_byte(MARKER_BYTE);
      send_byte(chan);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      for (int i = 0; i < len; i++)
         send_byte(($urandom_range(0, 15) == 0) ? MARKER_BYTE : 8'($urandom));
      frame_bytes += 4 + len;
   endtask

   // Bytes between frames, sometimes an empty frame header among them
   task automatic send_noise();
      logic [7:0] b;
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         if (b == MARKER_BYTE)
            b = 8'h25;
         send_byte(b);
      end
      if ($urandom_range(0, 2) == 0) begin
         send_byte(MARKER_BYTE);
         send_byte(8'($urandom));
         send_byte(8'h00);
         send_byte(8'h00);
      end
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 16'd0;
      if (r < 60)
         return 16'($urandom_range(1, 8));
      if (r < 92)
         return 16'($urandom_range(9, 40));
      if (r < 98)
         return 16'($urandom_range(41, 120));
      return 16'($urandom_range(256, 400));
   endfunction

   // Result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (drain_fast) begin
            rsp_tready = 1'b1;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready = 1'b1;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(100, 300)) @(negedge clock);
            else
               repeat ($urandom_range(0, 23)) @(negedge clock);
         end
      end
   end

   // Note accepted bytes and check results at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Stop a hung run
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // Main stimulus
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Dropped bytes outside any frame
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h23);
      // Empty frame, then single-byte media frame
      send_frame(8'h05, 16'd0);
      send_frame(8'h00, 16'd1);
      // Top channel, payload holding the marker byte and both byte extremes
      send_byte(MARKER_BYTE);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(MARKER_BYTE);
      send_byte(8'h00);
      send_byte(8'hff);
      // Lowest control channel
      send_frame(8'h01, 16'd2);

      // Long frame with a nonzero length high byte at full rate on both sides
      send_quiet = 1'b1;
      drain_fast = 1'b1;
      send_frame(8'h80, 16'h0104);
      send_quiet = 1'b0;
      drain_fast = 1'b0;

      // Random frames with noise between them
      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         if (frame_bytes > 100 && !hold_done) begin
            hold_req = 1'b1;
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 4) == 0)
            send_noise();
         else
            send_frame(pick_channel(), pick_length());
      end
      req_tvalid = 1'b0;

      // Drain and let the pipeline settle
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (sb.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
